// ===== rtl/lmlt_pkg.sv =====
// Shared types, constants and codes of the LCD mode and line timing block.
package lmlt_pkg;

   // Default timing of one frame.
   localparam int DefDotsPerLine  = 456;
   localparam int DefVisibleLines = 144;
   localparam int DefLastLine     = 153;

   // Field widths.
   localparam int DotW   = 9;
   localparam int LineW  = 8;
   localparam int ElapsW = 6;
   localparam int ModeW  = 2;

   // Mode thresholds, in dots from the start of the line.
   localparam int OamDots         = 80;
   localparam int OamTransferDots = 252;

   // Configuration register indexes.
   localparam logic [1:0] CsrCompareLine = 2'd0;
   localparam logic [1:0] CsrHblankIrqEn = 2'd1;
   localparam logic [1:0] CsrOamIrqEn    = 2'd2;
   localparam logic [1:0] CsrCoinIrqEn   = 2'd3;

   // Display modes.
   localparam logic [ModeW-1:0] ModeHblank   = 2'd0;
   localparam logic [ModeW-1:0] ModeVblank   = 2'd1;
   localparam logic [ModeW-1:0] ModeOam      = 2'd2;
   localparam logic [ModeW-1:0] ModeTransfer = 2'd3;

   // Configuration as seen by the timing core.
   typedef struct packed {
      logic [LineW-1:0] compare_line;
      logic             hblank_irq_enable;
      logic             oam_irq_enable;
      logic             coincidence_irq_enable;
   } cfg_type;

   // One result item.
   typedef struct packed {
      logic             frame_done;
      logic [LineW-1:0] finished_line;
      logic             line_done;
      logic             status_request;
      logic             vblank_request;
      logic             coincidence_flag;
      logic [LineW-1:0] current_line;
      logic [ModeW-1:0] lcd_mode;
   } result_type;

endpackage

// ===== rtl/lmlt_timing.sv =====
// Line timer, line counter, mode and request logic of the LCD timing block.
module lmlt_timing #(
   parameter int DOTS_PER_LINE = lmlt_pkg::DefDotsPerLine,
   parameter int VISIBLE_LINES = lmlt_pkg::DefVisibleLines,
   parameter int LAST_LINE     = lmlt_pkg::DefLastLine
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           step,
   input  logic [lmlt_pkg::ElapsW-1:0]    elapsed_dots,
   input  lmlt_pkg::cfg_type              cfg,
   output lmlt_pkg::result_type           result
);

   localparam int DotW  = lmlt_pkg::DotW;
   localparam int LineW = lmlt_pkg::LineW;
   localparam logic [DotW-1:0]  DotsReload = DotW'(DOTS_PER_LINE);
   localparam logic [DotW:0]    DotsWide   = (DotW+1)'(DOTS_PER_LINE);
   localparam logic [DotW:0]    OamAdd     = (DotW+1)'(lmlt_pkg::OamDots);
   localparam logic [DotW:0]    XferAdd    = (DotW+1)'(lmlt_pkg::OamTransferDots);
   localparam logic [LineW:0]   VisWide    = (LineW+1)'(VISIBLE_LINES);
   localparam logic [LineW:0]   LastWide   = (LineW+1)'(LAST_LINE);

   logic [DotW-1:0]           countdown_ff, countdown_in;
   logic [LineW-1:0]          line_ff, line_in;
   logic                      latch_ff, latch_in;
   logic [lmlt_pkg::ModeW-1:0] mode_ff, mode_in;

   logic [DotW-1:0]  cd_sub;
   logic [LineW:0]   next_line;
   logic             stat_mode;

   // Next state and result of one tick.
   always_comb begin
      cd_sub       = ({3'd0, elapsed_dots} >= countdown_ff) ?
                     '0 : countdown_ff - {3'd0, elapsed_dots};
      countdown_in = cd_sub;
      latch_in     = latch_ff;
      stat_mode    = 1'b0;
      mode_in      = mode_ff;
      next_line    = {1'b0, line_ff} + 1'b1;
      line_in      = line_ff;
      result       = '0;

      // Mode from the line and the timer after the subtraction.
      if ({1'b0, line_ff} >= VisWide) begin
         mode_in = lmlt_pkg::ModeVblank;
      end else if ({1'b0, cd_sub} + OamAdd >= DotsWide) begin
         mode_in   = lmlt_pkg::ModeOam;
         stat_mode = cfg.oam_irq_enable;
         latch_in  = 1'b1;
      end else if ({1'b0, cd_sub} + XferAdd >= DotsWide) begin
         mode_in  = lmlt_pkg::ModeTransfer;
         latch_in = 1'b0;
      end else begin
         mode_in   = lmlt_pkg::ModeHblank;
         stat_mode = !latch_ff && cfg.hblank_irq_enable;
         latch_in  = 1'b1;
      end

      // End of the line: reload the timer and advance the line counter.
      if (cd_sub == '0) begin
         countdown_in = DotsReload;
         if (next_line <= VisWide) begin
            result.line_done     = 1'b1;
            result.finished_line = line_ff;
         end
         if (next_line == VisWide) begin
            result.vblank_request = 1'b1;
            mode_in               = lmlt_pkg::ModeVblank;
         end
         if (next_line > LastWide || next_line[LineW]) begin
            line_in           = '0;
            result.frame_done = 1'b1;
         end else begin
            line_in = next_line[LineW-1:0];
         end
      end

      result.lcd_mode         = mode_in;
      result.current_line     = line_in;
      result.coincidence_flag = (line_in == cfg.compare_line);
      result.status_request   = stat_mode ||
                                (result.coincidence_flag && cfg.coincidence_irq_enable);
   end

   // Timing state, advanced once per tick.
   always_ff @(posedge clock) begin
      if (reset) begin
         countdown_ff <= DotsReload;
         line_ff      <= '0;
         latch_ff     <= 1'b0;
         mode_ff      <= lmlt_pkg::ModeHblank;
      end else if (step) begin
         countdown_ff <= countdown_in;
         line_ff      <= line_in;
         latch_ff     <= latch_in;
         mode_ff      <= mode_in;
      end
   end

endmodule

// ===== rtl/lcd_mode_and_line_timing.sv =====
// Top level of the LCD mode and line timing block.
// Each req item is one tick carrying the dot cycles elapsed since the last tick; it
// yields exactly one rsp item with the mode, the line after the tick and the request
// pulses. Items pass an input register, the timing update and a result register, so
// one item is taken every clock cycle while rsp_tready is high. The result is
// registered in the result register after the input register, and a stall on rsp
// holds it back. The combinational line and mode update sets that rate.
module lcd_mode_and_line_timing #(
   parameter int DOTS_PER_LINE = lmlt_pkg::DefDotsPerLine,
   parameter int VISIBLE_LINES = lmlt_pkg::DefVisibleLines,
   parameter int LAST_LINE     = lmlt_pkg::DefLastLine
) (
   input  logic        clock,
   input  logic        reset,
   // Input ticks; tdata: [5:0] elapsed_dots, [7:6] zero.
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,
   // Results; tdata: [1:0] lcd_mode, [9:2] current_line, [10] coincidence_flag,
   // [11] vblank_request, [12] status_request, [13] line_done,
   // [21:14] finished_line, [22] frame_done, [23] zero.
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [23:0] rsp_tdata,
   // Configuration writes.
   input  logic        csr_we,
   input  logic [1:0]  csr_index,
   input  logic [7:0]  csr_wdata
);

   localparam int ElapsW = lmlt_pkg::ElapsW;

   lmlt_pkg::cfg_type    cfg_ff;
   logic                 in_valid_ff;
   logic [ElapsW-1:0]    in_dots_ff;
   logic                 out_valid_ff;
   lmlt_pkg::result_type out_data_ff;
   lmlt_pkg::result_type result;
   logic                 out_free;
   logic                 step;

   // Handshake: the result register frees when taken, the input register when moved on.
   assign out_free   = !out_valid_ff || rsp_tready;
   assign step       = in_valid_ff && out_free;
   assign req_tready = !in_valid_ff || out_free;

   // Configuration registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_we) begin
         case (csr_index)
            lmlt_pkg::CsrCompareLine: cfg_ff.compare_line           <= csr_wdata;
            lmlt_pkg::CsrHblankIrqEn: cfg_ff.hblank_irq_enable      <= csr_wdata[0];
            lmlt_pkg::CsrOamIrqEn:    cfg_ff.oam_irq_enable         <= csr_wdata[0];
            lmlt_pkg::CsrCoinIrqEn:   cfg_ff.coincidence_irq_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   // Input register.
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_tready) begin
         in_valid_ff <= req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (req_tready && req_tvalid) begin
         in_dots_ff <= req_tdata[ElapsW-1:0];
      end
   end

   // Timing core.
   lmlt_timing #(
      .DOTS_PER_LINE (DOTS_PER_LINE),
      .VISIBLE_LINES (VISIBLE_LINES),
      .LAST_LINE     (LAST_LINE)
   ) u_timing (
      .clock        (clock),
      .reset        (reset),
      .step         (step),
      .elapsed_dots (in_dots_ff),
      .cfg          (cfg_ff),
      .result       (result)
   );

   // Result register.
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (out_free) begin
         out_valid_ff <= in_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (step) begin
         out_data_ff <= result;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_data_ff};

   // A wrap always lands on line zero.
   a_frame_line: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.frame_done |-> out_data_ff.current_line == '0)
      else $error("frame_done without line zero");

   // Entering vertical blank forces the vblank mode and reports line_done.
   a_vblank_mode: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_data_ff.vblank_request |->
         out_data_ff.lcd_mode == lmlt_pkg::ModeVblank && out_data_ff.line_done)
      else $error("vblank_request without vblank mode and line_done");

   // The finished line index is only reported with line_done.
   a_finished_zero: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !out_data_ff.line_done |-> out_data_ff.finished_line == '0)
      else $error("finished_line set without line_done");

   // A stalled item in the input register stays there.
   a_hold_input: assert property (@(posedge clock) disable iff (reset)
      in_valid_ff && !out_free |=> in_valid_ff && $stable(in_dots_ff))
      else $error("input item lost while stalled");

endmodule
